// ===== src/tlbrr_pkg.sv =====
// Shared types, constants and helper functions for the fully associative TLB.
// Used by the controller, the datapath, the top level and the port checker.
package tlbrr_pkg;

	localparam int ENTRIES    = 32;
	localparam int PAGE_BITS  = 11;
	localparam int FRAME_BITS = 10;
	localparam int STAMP_BITS = 32;
	localparam int SLOT_W     = $clog2(ENTRIES);
	localparam int LFSR_W     = 16;

	localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;
	localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;

	localparam logic [1:0] ACT_LOOKUP = 2'd0;
	localparam logic [1:0] ACT_FILL   = 2'd1;
	localparam logic [1:0] ACT_FLUSH  = 2'd2;

	typedef struct packed {
		logic [1:0]            action;
		logic [PAGE_BITS-1:0]  page_number;
		logic [FRAME_BITS-1:0] frame_number;
	} in_item_t;

	typedef struct packed {
		logic                  hit;
		logic [FRAME_BITS-1:0] found_frame;
		logic [SLOT_W-1:0]     slot;
		logic                  evicted;
	} out_item_t;

	typedef struct packed {
		logic latch_in;
		logic scan_start;
		logic scan_step;
		logic commit;
	} dp_cmd_t;

	typedef struct packed {
		logic need_scan;
		logic scan_last;
		logic out_free;
	} dp_stat_t;

	// Returns {found, index} of the lowest set bit.
	function automatic logic [SLOT_W:0] first_set(input logic [ENTRIES-1:0] vec);
		logic              found;
		logic [SLOT_W-1:0] idx;
		found = 1'b0;
		idx   = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (vec[i]) begin
				found = 1'b1;
				idx   = SLOT_W'(i);
			end
		end
		return {found, idx};
	endfunction

	function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] cur);
		logic [LFSR_W-1:0] nxt;
		nxt = cur >> 1;
		if (cur[0]) begin
			nxt = nxt ^ LFSR_TAPS;
		end
		return nxt;
	endfunction

endpackage

// ===== src/tlbrr_ctrl.sv =====
// Sequencing state machine for the TLB: accepts a beat, runs the victim scan
// when needed and tells the datapath when to commit. Depends on tlbrr_pkg.
module tlbrr_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  tlbrr_pkg::dp_stat_t stat,
	output tlbrr_pkg::dp_cmd_t  cmd
);
	import tlbrr_pkg::*;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_EXEC   = 2'd1;
	localparam logic [1:0] ST_SCAN   = 2'd2;
	localparam logic [1:0] ST_FINISH = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.latch_in = 1'b1;
					state_d      = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (stat.need_scan) begin
					cmd.scan_start = 1'b1;
					state_d        = ST_SCAN;
				end else if (stat.out_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (stat.scan_last) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (stat.out_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== src/tlbrr_datapath.sv =====
// Entry storage, match logic, victim selection and the output register of the TLB.
// Driven by tlbrr_ctrl through command and status structs. Depends on tlbrr_pkg.
module tlbrr_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic                 cfg_data,
	input  tlbrr_pkg::in_item_t  in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output tlbrr_pkg::out_item_t out_data,
	input  tlbrr_pkg::dp_cmd_t   cmd,
	output tlbrr_pkg::dp_stat_t  stat
);
	import tlbrr_pkg::*;

	in_item_t              item_q;
	logic                  mode_q;
	logic [ENTRIES-1:0]    valid_q;
	logic [PAGE_BITS-1:0]  page_q  [ENTRIES];
	logic [FRAME_BITS-1:0] frame_q [ENTRIES];
	logic [STAMP_BITS-1:0] stamp_q [ENTRIES];
	logic [STAMP_BITS-1:0] counter_q;
	logic [LFSR_W-1:0]     lfsr_q;
	logic [SLOT_W-1:0]     scan_idx_q;
	logic [SLOT_W-1:0]     best_q;
	logic [STAMP_BITS-1:0] least_q;
	logic                  out_valid_q;
	out_item_t             out_q;

	logic [ENTRIES-1:0]    match_vec;
	logic [SLOT_W:0]       hit_enc;
	logic [SLOT_W:0]       free_enc;
	logic                  hit_any;
	logic [SLOT_W-1:0]     hit_idx;
	logic                  free_any;
	logic [SLOT_W-1:0]     free_idx;
	logic [LFSR_W-1:0]     lfsr_next;
	logic [SLOT_W-1:0]     fill_idx;
	logic [STAMP_BITS-1:0] scan_rd;
	out_item_t             out_next;

	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			match_vec[i] = valid_q[i] && (page_q[i] == item_q.page_number);
		end
	end

	assign hit_enc   = first_set(match_vec);
	assign free_enc  = first_set(~valid_q);
	assign hit_any   = hit_enc[SLOT_W];
	assign hit_idx   = hit_enc[SLOT_W-1:0];
	assign free_any  = free_enc[SLOT_W];
	assign free_idx  = free_enc[SLOT_W-1:0];
	assign lfsr_next = lfsr_step(lfsr_q);
	assign scan_rd   = stamp_q[scan_idx_q];

	// The entry count is a power of two, so the modulo is the low bits of the LFSR.
	always_comb begin
		if (free_any) begin
			fill_idx = free_idx;
		end else if (mode_q) begin
			fill_idx = lfsr_next[SLOT_W-1:0];
		end else begin
			fill_idx = best_q;
		end
	end

	always_comb begin
		out_next = '0;
		case (item_q.action)
			ACT_LOOKUP: begin
				if (hit_any) begin
					out_next.hit         = 1'b1;
					out_next.found_frame = frame_q[hit_idx];
					out_next.slot        = hit_idx;
				end
			end
			ACT_FILL: begin
				out_next.slot    = fill_idx;
				out_next.evicted = !free_any;
			end
			default: begin
				out_next = '0;
			end
		endcase
	end

	assign stat.need_scan = (item_q.action == ACT_FILL) && (&valid_q) && !mode_q;
	assign stat.scan_last = (scan_idx_q == SLOT_W'(ENTRIES - 1));
	assign stat.out_free  = !out_valid_q || !out_stall;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= 1'b0;
			valid_q     <= '0;
			stamp_q     <= '{default: '0};
			counter_q   <= '0;
			lfsr_q      <= LFSR_SEED;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				mode_q <= cfg_data;
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.commit) begin
				case (item_q.action)
					ACT_LOOKUP: begin
						if (hit_any && !mode_q) begin
							stamp_q[hit_idx] <= counter_q;
							counter_q        <= counter_q + 1'b1;
						end
					end
					ACT_FILL: begin
						valid_q[fill_idx] <= 1'b1;
						if (!mode_q) begin
							stamp_q[fill_idx] <= counter_q;
							counter_q         <= counter_q + 1'b1;
						end else if (!free_any) begin
							lfsr_q <= lfsr_next;
						end
					end
					ACT_FLUSH: begin
						valid_q <= '0;
					end
					default: begin
						valid_q <= valid_q;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			item_q <= in_data;
		end
		if (cmd.commit) begin
			out_q <= out_next;
			if (item_q.action == ACT_FILL) begin
				page_q[fill_idx]  <= item_q.page_number;
				frame_q[fill_idx] <= item_q.frame_number;
			end
		end
		if (cmd.scan_start) begin
			scan_idx_q <= SLOT_W'(1);
			best_q     <= '0;
			least_q    <= stamp_q[0];
		end else if (cmd.scan_step) begin
			scan_idx_q <= scan_idx_q + 1'b1;
			if (scan_rd < least_q) begin
				least_q <= scan_rd;
				best_q  <= scan_idx_q;
			end
		end
	end

endmodule

// ===== src/tlb_lru_random_replace_top.sv =====
// Top level of the fully associative TLB with LRU or pseudo-random replacement.
// Instantiates tlbrr_ctrl and tlbrr_datapath. Depends on tlbrr_pkg.
//
// Usage: one beat on the input channel (in_valid, in_stall, in_data) carries an
// action, a page number and a frame number. Every beat produces exactly one
// beat on the output channel (out_valid, out_stall, out_data).
// A fill that must evict in LRU mode scans the entry stamps one per cycle
// through the datapath's stamp comparator before its result is committed.
// Every other beat is latched into the input register and its result is
// committed to the output register as soon as that register is free.
// The block holds one item at a time; in_stall is low only when no item is in
// progress. A finished result sits in the output register while the next beat
// is accepted. If the receiver stalls, that result holds and the item after it
// waits until the output register frees.
// The user must write the replace_mode register with cfg_we and cfg_data only
// while idle; the block does not enforce this. Reset clears all valid bits and
// stamps, the stamp counter and the output, loads the LFSR seed and selects LRU
// mode. No clearing pass is needed.
module tlb_lru_random_replace_top (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic                 cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  tlbrr_pkg::in_item_t  in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output tlbrr_pkg::out_item_t out_data
);
	import tlbrr_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	tlbrr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	tlbrr_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule

// ===== src/tlbrr_checker.sv =====
// Port-level assertions for the TLB top level, attached with a bind statement.
// Depends on tlbrr_pkg and tlb_lru_random_replace_top.
module tlbrr_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_stall,
	input logic                 out_valid,
	input logic                 out_stall,
	input tlbrr_pkg::out_item_t out_data
);
	import tlbrr_pkg::*;

	// The block works on one beat at a time, so it is busy right after a beat.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input accepted on two consecutive cycles");

	a_out_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("stalled result dropped");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_data))
		else $error("stalled result changed");

	a_miss_zero_frame: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.hit |-> out_data.found_frame == '0)
		else $error("frame returned without a hit");

	a_hit_not_evict: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.hit |-> !out_data.evicted)
		else $error("hit and eviction reported together");

endmodule

bind tlb_lru_random_replace_top tlbrr_checker u_tlbrr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

// ===== tb/tlb_translation_checker.sv =====
`timescale 1ns / 1ps
// Checker for the TLB: follows both channels and the replace_mode write port,
// predicts each result beat and compares it. Depends on tlbrr_pkg.
module tlb_translation_checker (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic                 cfg_data,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  tlbrr_pkg::in_item_t  in_data,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  tlbrr_pkg::out_item_t out_data,
	output int                   fail_count,
	output int                   outstanding
);
	import tlbrr_pkg::*;

	logic [ENTRIES-1:0]    live;
	logic [PAGE_BITS-1:0]  page_tag [ENTRIES];
	logic [FRAME_BITS-1:0] frame_of [ENTRIES];
	logic [STAMP_BITS-1:0] stamp_of [ENTRIES];
	logic [STAMP_BITS-1:0] stamp_now;
	logic [LFSR_W-1:0]     lfsr;
	logic                  random_mode;
	out_item_t             expected_results [$];

	task automatic translate_beat(input in_item_t beat, output out_item_t res);
		int                target;
		logic [LFSR_W-1:0] nxt;
		res = '0;
		case (beat.action)
			ACT_LOOKUP: begin
				for (int i = 0; i < ENTRIES; i++) begin
					if (!res.hit && live[i] && page_tag[i] == beat.page_number) begin
						if (!random_mode) begin
							stamp_of[i] = stamp_now;
							stamp_now = stamp_now + 1'b1;
						end
						res.hit = 1'b1;
						res.found_frame = frame_of[i];
						res.slot = SLOT_W'(i);
					end
				end
			end
			ACT_FILL: begin
				target = -1;
				for (int i = 0; i < ENTRIES; i++) begin
					if (target < 0 && !live[i]) begin
						target = i;
					end
				end
				if (target < 0) begin
					res.evicted = 1'b1;
					if (random_mode) begin
						nxt = lfsr >> 1;
						if (lfsr[0]) begin
							nxt = nxt ^ LFSR_TAPS;
						end
						lfsr = nxt;
						target = int'(lfsr[SLOT_W-1:0]);
					end else begin
						target = 0;
						for (int i = 1; i < ENTRIES; i++) begin
							if (stamp_of[i] < stamp_of[target]) begin
								target = i;
							end
						end
						stamp_of[target] = '0;
					end
				end
				if (!random_mode) begin
					stamp_of[target] = stamp_now;
					stamp_now = stamp_now + 1'b1;
				end
				page_tag[target] = beat.page_number;
				frame_of[target] = beat.frame_number;
				live[target] = 1'b1;
				res.slot = SLOT_W'(target);
			end
			ACT_FLUSH: begin
				live = '0;
			end
			default: begin
			end
		endcase
	endtask

	task automatic flag_beat(input string what, input out_item_t want, input out_item_t got);
		if (fail_count < 10) begin
			$display("%0t: %s: expected hit=%0d frame=%0d slot=%0d evicted=%0d,",
				$realtime, what, want.hit, want.found_frame, want.slot, want.evicted);
			$display("    got hit=%0d frame=%0d slot=%0d evicted=%0d",
				got.hit, got.found_frame, got.slot, got.evicted);
		end
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		out_item_t res;
		if (!arst_n) begin
			live = '0;
			for (int i = 0; i < ENTRIES; i++) begin
				stamp_of[i] = '0;
			end
			stamp_now = '0;
			lfsr = LFSR_SEED;
			random_mode = 1'b0;
			expected_results.delete();
			fail_count = 0;
			outstanding <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					flag_beat("result beat with none expected", '0, out_data);
				end else begin
					want = expected_results.pop_front();
					if (out_data.hit !== want.hit || out_data.found_frame !== want.found_frame ||
						out_data.slot !== want.slot || out_data.evicted !== want.evicted) begin
						flag_beat("result mismatch", want, out_data);
					end
				end
			end
			if (cfg_we) begin
				random_mode = cfg_data;
			end
			if (in_valid && !in_stall) begin
				translate_beat(in_data, res);
				expected_results.push_back(res);
			end
			outstanding <= expected_results.size();
		end
	end

endmodule

// ===== tb/tlb_lru_random_replace_top_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for tlb_lru_random_replace_top: drives directed and random beats
// in bursts under both replacement modes and gives the verdict of the checker.
// Depends on tlbrr_pkg, tlb_lru_random_replace_top and tlb_translation_checker.
module tlb_lru_random_replace_top_tb;
	import tlbrr_pkg::*;

	localparam logic [1:0] ACT_UNUSED     = 2'd3;
	localparam int         WATCHDOG_LIMIT = 4000;
	localparam int         SETTLE_CYCLES  = ENTRIES + 4;
	localparam int         HOT_PAGES      = 48;
	localparam int         PHASES         = 6;
	localparam int         PHASE_BEATS    = 200;

	typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY} stall_style_t;

	logic      clk;
	logic      arst_n;
	logic      cfg_we;
	logic      cfg_data;
	logic      in_valid;
	logic      in_stall;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_stall;
	out_item_t out_data;
	int        fail_count;
	int        outstanding;
	int        idle_cycles = 0;
	int        burst_left = 0;

	logic [PAGE_BITS-1:0] hot_page [HOT_PAGES];

	tlb_lru_random_replace_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	tlb_translation_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		stall_style_t style;
		out_stall = 1'b0;
		forever begin
			style = stall_style_t'($urandom_range(0, 2));
			repeat ($urandom_range(50, 300)) begin
				@(negedge clk);
				case (style)
					STALL_NONE:  out_stall <= 1'b0;
					STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
					default:     out_stall <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
			(!in_valid && outstanding == 0)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("** tlb_lru_random_replace_top: FAILED **");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic in_item_t make_beat(input logic [1:0] act, input int page, input int frame);
		in_item_t b;
		b.action = act;
		b.page_number = PAGE_BITS'(page);
		b.frame_number = FRAME_BITS'(frame);
		return b;
	endfunction

	function automatic in_item_t random_beat();
		int         roll;
		logic [1:0] act;
		roll = $urandom_range(0, 999);
		if (roll < 540) begin
			act = ACT_LOOKUP;
		end else if (roll < 990) begin
			act = ACT_FILL;
		end else if (roll < 995) begin
			act = ACT_FLUSH;
		end else begin
			act = ACT_UNUSED;
		end
		if ($urandom_range(0, 9) < 8) begin
			return make_beat(act, hot_page[$urandom_range(0, HOT_PAGES - 1)], $urandom);
		end
		return make_beat(act, $urandom, $urandom);
	endfunction

	// Called at a falling edge; returns at the falling edge after the beat is taken.
	task automatic send_beat(input in_item_t beat);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if ($urandom_range(0, 3) != 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 10)) @(negedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		in_data <= beat;
		do @(posedge clk); while (!(in_valid === 1'b1 && in_stall === 1'b0));
		@(negedge clk);
	endtask

	task automatic drain();
		while (outstanding != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_mode(input logic mode);
		in_valid <= 1'b0;
		drain();
		cfg_we <= 1'b1;
		cfg_data <= mode;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_data = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		for (int i = 0; i < HOT_PAGES; i++) begin
			hot_page[i] = PAGE_BITS'($urandom);
		end
		hot_page[0] = '0;
		hot_page[1] = '1;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_beat(make_beat(ACT_LOOKUP, 0, 0));
		send_beat(make_beat(ACT_UNUSED, 2047, 1023));
		send_beat(make_beat(ACT_FILL, 2047, 1023));
		send_beat(make_beat(ACT_FILL, 0, 0));
		send_beat(make_beat(ACT_FILL, 2047, 'h155));
		send_beat(make_beat(ACT_LOOKUP, 2047, 0));
		send_beat(make_beat(ACT_LOOKUP, 0, 1023));
		send_beat(make_beat(ACT_LOOKUP, 5, 0));
		send_beat(make_beat(ACT_FLUSH, 2047, 1023));
		send_beat(make_beat(ACT_LOOKUP, 2047, 0));
		send_beat(make_beat(ACT_FILL, 'h2AA, 'h2AA));
		send_beat(make_beat(ACT_LOOKUP, 'h2AA, 'h155));

		for (int phase = 0; phase < PHASES; phase++) begin
			set_mode((phase % 2) == 0);
			repeat (PHASE_BEATS) send_beat(random_beat());
		end

		in_valid <= 1'b0;
		drain();
		if (fail_count == 0) begin
			$display("** tlb_lru_random_replace_top: PASSED **");
		end else begin
			$display("** tlb_lru_random_replace_top: FAILED **");
		end
		$finish;
	end

endmodule
